// ===== sv/fixed_point_alu_unit_macros.svh =====
// assertion helpers for the fixed-point alu
`ifndef FIXED_POINT_ALU_UNIT_MACROS_SVH
`define FIXED_POINT_ALU_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define FPA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fixed-point alu check failed");
`define FPA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("fixed-point alu check failed");
`else
`define FPA_ASSERT(lbl, clk, rst, prop)
`define FPA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/fpa_pkg.sv =====
`default_nettype none
package fpa_pkg;

   localparam logic [2:0] FUNC_ADD = 3'd0;
   localparam logic [2:0] FUNC_SUB = 3'd1;
   localparam logic [2:0] FUNC_MUL = 3'd2;
   localparam logic [2:0] FUNC_DIV = 3'd3;
   localparam logic [2:0] FUNC_MIN = 3'd4;
   localparam logic [2:0] FUNC_MAX = 3'd5;

   // classified operation as it waits for the back end
   typedef struct packed {
      logic        is_mul;
      logic        is_div;
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      logic        neg;
      logic [31:0] early;
      logic        ovf;
      logic        dz;
      logic        less;
      logic        equal;
      logic        greater;
   } fpa_item_type;

endpackage
`default_nettype wire

// ===== sv/fpa_front.sv =====
`default_nettype none
module fpa_front #(
   parameter int WORD_BITS = 32
) (
   input  wire logic [2:0]          func,
   input  wire logic [31:0]         operand_a,
   input  wire logic [31:0]         operand_b,
   output fpa_pkg::fpa_item_type    item
);
   import fpa_pkg::*;

   localparam int SH = 32 - WORD_BITS;
   localparam logic signed [32:0] MAXV = 33'sd1 <<< (WORD_BITS - 1);
   localparam logic signed [32:0] HI = MAXV - 33'sd1;
   localparam logic signed [32:0] LO = -MAXV;

   logic signed [31:0] a_x, b_x;
   logic signed [32:0] sum;
   logic        sum_ovf;
   logic [31:0] sum_sat;

   assign a_x = $signed(operand_a << SH) >>> SH;
   assign b_x = $signed(operand_b << SH) >>> SH;

   always_comb begin
      if (func == FUNC_SUB) begin
         sum = 33'({a_x[31], a_x}) - 33'({b_x[31], b_x});
      end else begin
         sum = 33'({a_x[31], a_x}) + 33'({b_x[31], b_x});
      end
      sum_ovf = 1'b0;
      sum_sat = sum[31:0];
      if (sum > HI) begin
         sum_ovf = 1'b1;
         sum_sat = HI[31:0];
      end else if (sum < LO) begin
         sum_ovf = 1'b1;
         sum_sat = LO[31:0];
      end
   end

   always_comb begin
      item.is_mul  = (func == FUNC_MUL);
      item.is_div  = (func == FUNC_DIV) && (b_x != 32'sd0);
      item.mag_a   = a_x[31] ? 32'd0 - a_x : a_x;
      item.mag_b   = b_x[31] ? 32'd0 - b_x : b_x;
      item.neg     = a_x[31] ^ b_x[31];
      item.less    = a_x < b_x;
      item.equal   = a_x == b_x;
      item.greater = a_x > b_x;
      item.dz      = (func == FUNC_DIV) && (b_x == 32'sd0);
      item.ovf     = 1'b0;
      item.early   = 32'd0;
      case (func)
         FUNC_ADD, FUNC_SUB: begin
            item.ovf   = sum_ovf;
            item.early = sum_sat;
         end
         FUNC_MIN: item.early = (a_x < b_x) ? a_x : b_x;
         FUNC_MAX: item.early = (a_x > b_x) ? a_x : b_x;
         default:  item.early = 32'd0;
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/fpa_queue.sv =====
`default_nettype none
module fpa_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire fpa_pkg::fpa_item_type push_item,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       head_valid,
   output fpa_pkg::fpa_item_type      head_item
);
   import fpa_pkg::*;

   fpa_item_type slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full       = cnt_ff == 2'd2;
   assign head_valid = cnt_ff != 2'd0;
   assign head_item  = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff ^ do_push;
      rd_in  = rd_ff ^ do_pop;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== sv/fpa_back.sv =====
`default_nettype none
`include "fixed_point_alu_unit_macros.svh"
module fpa_back #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire fpa_pkg::fpa_item_type in_item,
   output logic                       in_pop,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output logic [31:0]                out_value,
   output logic [4:0]                 out_flags
);
   import fpa_pkg::*;

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int QW = W + F;
   localparam int QX = ((2 * W > QW) ? 2 * W : QW) + 1;
   localparam int NV = QW + 3;
   localparam logic [QX-1:0] HALF = QX'((64'd1 << F) >> 1);
   localparam logic [QX-1:0] LIM  = QX'(1) << (W - 1);

   typedef struct packed {
      fpa_item_type     info;
      logic [2*W-1:0]   prod;
      logic [W:0]       rem;
      logic [QW-1:0]    num;
      logic [QW-1:0]    quo;
   } stage_type;

   typedef struct packed {
      fpa_item_type  info;
      logic [QX-1:0] qmag;
   } round_type;

   stage_type st_ff [QW+1];
   stage_type st_in [QW+1];
   round_type rnd_ff, rnd_in;
   logic [31:0] val_ff, val_in;
   logic [4:0]  flg_ff, flg_in;
   logic [NV-1:0] vld_ff, vld_in;
   logic adv;

   assign adv      = !vld_ff[NV-1] || out_ready;
   assign in_pop   = adv;
   assign out_valid = vld_ff[NV-1];
   assign out_value = val_ff;
   assign out_flags = flg_ff;

   assign vld_in = {vld_ff[NV-2:0], in_valid};

   always_comb begin
      logic [W:0] rsh;
      logic [W:0] mbx;
      // stage 0 multiplies and loads the divider
      st_in[0].info = in_item;
      st_in[0].prod = in_item.mag_a[W-1:0] * in_item.mag_b[W-1:0];
      st_in[0].rem  = '0;
      st_in[0].num  = QW'({in_item.mag_a[W-1:0]} << F);
      st_in[0].quo  = '0;
      // one restoring quotient bit per stage
      for (int k = 1; k <= QW; k++) begin
         st_in[k] = st_ff[k-1];
         mbx = {1'b0, st_ff[k-1].info.mag_b[W-1:0]};
         rsh = {st_ff[k-1].rem[W-1:0], st_ff[k-1].num[QW-1]};
         st_in[k].num = st_ff[k-1].num << 1;
         if (rsh >= mbx) begin
            st_in[k].rem = rsh - mbx;
            st_in[k].quo = {st_ff[k-1].quo[QW-2:0], 1'b1};
         end else begin
            st_in[k].rem = rsh;
            st_in[k].quo = {st_ff[k-1].quo[QW-2:0], 1'b0};
         end
      end
   end

   // round half away from zero on the magnitude
   always_comb begin
      logic [QX-1:0] psum;
      logic          up;
      rnd_in.info = st_ff[QW].info;
      psum = QX'(st_ff[QW].prod) + HALF;
      up = {st_ff[QW].rem, 1'b0} >= {2'b00, st_ff[QW].info.mag_b[W-1:0]};
      if (st_ff[QW].info.is_mul) begin
         rnd_in.qmag = psum >> F;
      end else begin
         rnd_in.qmag = QX'(st_ff[QW].quo) + QX'(up);
      end
   end

   // saturate and pack
   always_comb begin
      logic [W-1:0] res_w;
      logic         ovf;
      res_w = '0;
      ovf   = 1'b0;
      if (rnd_ff.info.neg) begin
         if (rnd_ff.qmag > LIM) begin
            ovf   = 1'b1;
            res_w = LIM[W-1:0];
         end else begin
            res_w = W'(QX'(0) - rnd_ff.qmag);
         end
      end else if (rnd_ff.qmag >= LIM) begin
         ovf   = 1'b1;
         res_w = W'(LIM - QX'(1));
      end else begin
         res_w = rnd_ff.qmag[W-1:0];
      end
      if (rnd_ff.info.is_mul || rnd_ff.info.is_div) begin
         val_in = 32'($signed(res_w));
         flg_in = {1'b0, ovf, rnd_ff.info.greater, rnd_ff.info.equal, rnd_ff.info.less};
      end else begin
         val_in = rnd_ff.info.early;
         flg_in = {rnd_ff.info.dz, rnd_ff.info.ovf, rnd_ff.info.greater,
                   rnd_ff.info.equal, rnd_ff.info.less};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= QW; k++) begin
            st_ff[k] <= st_in[k];
         end
         rnd_ff <= rnd_in;
         val_ff <= val_in;
         flg_ff <= flg_in;
      end
   end

   `FPA_ASSERT(a_flags_onehot, clock, reset, out_valid |-> $onehot(out_flags[2:0]))
   `FPA_ASSERT(a_dz_zero, clock, reset, (out_valid && out_flags[4]) |-> (out_value == 32'd0 && !out_flags[3]))
   `FPA_ASSERT(a_hold_stalled, clock, reset, (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))

endmodule
`default_nettype wire

// ===== sv/fixed_point_alu_unit.sv =====
// Signed fixed-point ALU: add, subtract, multiply, divide, min and max on two
// WORD_BITS-bit raw operands with FRAC_BITS fraction bits. Multiply and divide
// round half away from zero; out-of-range results saturate and set overflowed,
// divide by zero returns 0 with divided_by_zero set. One transfer is accepted
// per cycle while the queue is not full; every operation passes through the queue
// and then the execution pipeline, where the divider forms one quotient bit per
// pipeline stage before rounding and saturation; the pipeline halts while the result side stalls.
// A two-entry queue sits between the input decode and the execution pipeline.
`default_nettype none
module fixed_point_alu_unit #(
   parameter int FRAC_BITS = 8,
   parameter int WORD_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // func[2:0], operand_a[34:3], operand_b[66:35]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // result_value[31:0], a_less, a_equal, a_greater,
                                         // overflowed, divided_by_zero
);
   import fpa_pkg::*;

   fpa_item_type cls_item, head_item;
   logic full, head_valid, pop;
   logic [31:0] value;
   logic [4:0]  flags;

   fpa_front #(.WORD_BITS(WORD_BITS)) u_front (
      .func      (req_tdata[2:0]),
      .operand_a (req_tdata[34:3]),
      .operand_b (req_tdata[66:35]),
      .item      (cls_item)
   );

   fpa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid),
      .push_item  (cls_item),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   assign req_tready = !full;

   fpa_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (head_valid),
      .in_item   (head_item),
      .in_pop    (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (value),
      .out_flags (flags)
   );

   assign rsp_tdata = {3'b000, flags, value};

endmodule
`default_nettype wire
